### rtl/unique_fifo_queue_defines.svh
// assertion macros for the unique fifo queue
`ifndef UNIQUE_FIFO_QUEUE_DEFINES_SVH
`define UNIQUE_FIFO_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define UFQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("ufq assertion failed");
`define UFQ_ASSERT_NEXT(lbl, cause, effect) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cause) |=> (effect)) \
        else $error("ufq assertion failed");
`else
`define UFQ_ASSERT(lbl, prop)
`define UFQ_ASSERT_NEXT(lbl, cause, effect)
`endif

`endif

### rtl/ufq_pkg.sv
`timescale 1ns / 1ps

package ufq_pkg;

    localparam int DATA_W = 32;
    localparam int OCC_W  = 5;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_DUMP = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]               op;
        logic signed [DATA_W-1:0] value;
    } t_request;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] data;
        logic [OCC_W-1:0]         occupancy;
        logic                     last;
    } t_result;

endpackage

### rtl/ufq_mem.sv
`timescale 1ns / 1ps

module ufq_mem
    import ufq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/unique_fifo_queue.sv
`timescale 1ns / 1ps
// channel   ports                       handshake
// request   i_request (t_request)       start high while busy low
// result    o_result (t_result)         o_valid, one cycle, no back-pressure
//
// each result shows the cycle after it forms
// push over n entries (none when empty): one entry read and compared per cycle
// pop: the head entry is read, then its result shows in the same cycle that busy falls
// dump of n entries: each entry read in order from the head and shown as a result, the last as busy falls
// unused op code, empty push, pop or dump: no read, the result shows as busy falls
// reset is synchronous and active low, the store is not cleared; results cannot be held off

`include "unique_fifo_queue_defines.svh"

module unique_fifo_queue
    import ufq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_request i_request,
    output logic     busy,
    output logic     o_valid,
    output t_result  o_result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_READ   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state                   r_state, n_state;
    logic [1:0]               r_op, n_op;
    logic signed [DATA_W-1:0] r_value, n_value;
    logic [AW-1:0]            r_head, n_head;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            r_idx, n_idx;
    logic [CW-1:0]            r_len, n_len;
    logic [AW-1:0]            r_rd_ptr, n_rd_ptr;
    logic                     r_pend, n_pend;
    logic                     r_pend_last, n_pend_last;
    logic                     r_hit, n_hit;
    logic                     r_out_vld, n_out_vld;
    t_result                  r_out, n_out;

    logic                     mem_we;
    logic                     mem_re;
    logic [DATA_W-1:0]        mem_rdata;
    logic [CW:0]              tail_sum;
    logic [CW:0]              tail_fold;

    function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
        logic [AW-1:0] q;
        if (p == AW'(DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + AW'(1);
        end
        return q;
    endfunction

    ufq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (tail_fold[AW-1:0]),
        .i_wdata (r_value),
        .i_re    (mem_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (mem_rdata)
    );

    // tail slot, head + count folded once into the ring
    assign tail_sum  = (CW+1)'(r_head) + (CW+1)'(r_count);
    assign tail_fold = (tail_sum >= (CW+1)'(DEPTH)) ? tail_sum - (CW+1)'(DEPTH) : tail_sum;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_value     = r_value;
        n_head      = r_head;
        n_count     = r_count;
        n_idx       = r_idx;
        n_len       = r_len;
        n_rd_ptr    = r_rd_ptr;
        n_pend      = 1'b0;
        n_pend_last = 1'b0;
        n_hit       = r_hit;
        n_out_vld   = 1'b0;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_re      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op     = i_request.op;
                    n_value  = i_request.value;
                    n_hit    = 1'b0;
                    n_idx    = '0;
                    n_rd_ptr = r_head;
                    case (i_request.op)
                        OP_PUSH: n_len = r_count;
                        OP_POP:  n_len = (r_count != '0) ? CW'(1) : '0;
                        OP_DUMP: n_len = r_count;
                        default: n_len = '0;
                    endcase
                    n_state = (n_len != '0) ? S_READ : S_FINISH;
                end
            end

            S_READ: begin
                if (r_idx < r_len) begin
                    mem_re      = 1'b1;
                    n_rd_ptr    = ptr_next(r_rd_ptr);
                    n_idx       = r_idx + CW'(1);
                    n_pend      = 1'b1;
                    n_pend_last = ((r_idx + CW'(1)) == r_len);
                end
                if (r_pend) begin
                    case (r_op)
                        OP_PUSH: begin
                            n_hit = r_hit | (mem_rdata == r_value);
                            if (r_pend_last) begin
                                n_state = S_FINISH;
                            end
                        end
                        OP_POP: begin
                            n_head              = ptr_next(r_head);
                            n_count             = r_count - CW'(1);
                            n_out_vld           = 1'b1;
                            n_out.status        = ST_OK;
                            n_out.data          = mem_rdata;
                            n_out.occupancy     = OCC_W'(r_count - CW'(1));
                            n_out.last          = 1'b1;
                            n_state             = S_IDLE;
                        end
                        default: begin
                            n_out_vld           = 1'b1;
                            n_out.status        = ST_OK;
                            n_out.data          = mem_rdata;
                            n_out.occupancy     = OCC_W'(r_count);
                            n_out.last          = r_pend_last;
                            if (r_pend_last) begin
                                n_state = S_IDLE;
                            end
                        end
                    endcase
                end
            end

            S_FINISH: begin
                n_state         = S_IDLE;
                n_out_vld       = 1'b1;
                n_out.data      = '0;
                n_out.last      = 1'b1;
                n_out.occupancy = OCC_W'(r_count);
                case (r_op)
                    OP_PUSH: begin
                        if (r_hit) begin
                            n_out.status = ST_DUP;
                        end else if (r_count == CW'(DEPTH)) begin
                            n_out.status = ST_FULL;
                        end else begin
                            mem_we          = 1'b1;
                            n_count         = r_count + CW'(1);
                            n_out.status    = ST_OK;
                            n_out.occupancy = OCC_W'(r_count + CW'(1));
                        end
                    end
                    OP_POP:  n_out.status = ST_EMPTY;
                    OP_DUMP: n_out.status = ST_EMPTY;
                    default: n_out.status = ST_OK;
                endcase
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_len       <= '0;
            r_rd_ptr    <= '0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_hit       <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_len       <= n_len;
            r_rd_ptr    <= n_rd_ptr;
            r_pend      <= n_pend;
            r_pend_last <= n_pend_last;
            r_hit       <= n_hit;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_value <= n_value;
        r_out   <= n_out;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    `UFQ_ASSERT(a_count_bound, r_count <= CW'(DEPTH))
    `UFQ_ASSERT(a_head_bound, r_head <= AW'(DEPTH - 1))
    `UFQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `UFQ_ASSERT(a_last_frees, o_valid && o_result.last |-> !busy)
    `UFQ_ASSERT(a_pend_in_read, r_pend |-> r_state == S_READ)

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ufq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = QUEUE_DEPTH + 8;
    localparam int RANDOM_REQUESTS = 400;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        t_request    req;
        int unsigned gap_after;
        bit          wait_drained;
    } t_pending;

    logic     i_clk;
    logic     i_rst_n = 1'b0;
    logic     start = 1'b0;
    t_request i_request = '0;
    logic     busy;
    logic     o_valid;
    t_result  o_result;

    t_pending                 pending_requests[$];
    t_result                  awaited_results[$];
    logic signed [DATA_W-1:0] held_values[$];

    int unsigned idle_left = 0;
    int unsigned n_accepted = 0;
    int unsigned n_total = 0;
    int unsigned n_results = 0;
    int unsigned n_dup = 0;
    int unsigned n_full = 0;
    int unsigned n_empty = 0;
    int unsigned mismatches = 0;
    int unsigned stall_cycles = 0;
    logic        drained = 1'b1;

    unique_fifo_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_request(i_request),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void queue_result(logic [1:0] status, logic signed [DATA_W-1:0] data,
                                         logic last);
        t_result res;
        res.status    = status;
        res.data      = data;
        res.occupancy = OCC_W'(held_values.size());
        res.last      = last;
        awaited_results.push_back(res);
        case (status)
            ST_DUP:   n_dup++;
            ST_FULL:  n_full++;
            ST_EMPTY: n_empty++;
            default:  ;
        endcase
    endfunction

    // unique queue behaviour on the held values
    function automatic void apply_request(t_request req);
        bit                       present;
        logic signed [DATA_W-1:0] oldest;
        present = 1'b0;
        case (req.op)
            OP_PUSH: begin
                foreach (held_values[i])
                    if (held_values[i] == req.value)
                        present = 1'b1;
                if (present) begin
                    queue_result(ST_DUP, '0, 1'b1);
                end else if (held_values.size() >= QUEUE_DEPTH) begin
                    queue_result(ST_FULL, '0, 1'b1);
                end else begin
                    held_values.push_back(req.value);
                    queue_result(ST_OK, '0, 1'b1);
                end
            end
            OP_POP: begin
                if (held_values.size() == 0) begin
                    queue_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    oldest = held_values.pop_front();
                    queue_result(ST_OK, oldest, 1'b1);
                end
            end
            OP_DUMP: begin
                if (held_values.size() == 0)
                    queue_result(ST_EMPTY, '0, 1'b1);
                else
                    foreach (held_values[i])
                        queue_result(ST_OK, held_values[i], i == held_values.size() - 1);
            end
            default: begin
                queue_result(ST_OK, '0, 1'b1);
            end
        endcase
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return DATA_W'($urandom_range(0, 19)) - DATA_W'(10);
        else if (r < 64)
            return (r[0]) ? 32'h8000_0000 : 32'h7fff_ffff;
        else
            return $urandom;
    endfunction

    function automatic void add_request(logic [1:0] op, logic signed [DATA_W-1:0] value,
                                        int unsigned gap_after, bit wait_drained);
        t_pending item;
        item.req.op       = op;
        item.req.value    = value;
        item.gap_after    = gap_after;
        item.wait_drained = wait_drained;
        pending_requests.push_back(item);
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: wrong %s, expected 'h%0h, actual 'h%0h", $time, field, want, got);
        end
    endtask

    // driver
    always @(posedge i_clk) begin : driver
        t_pending next_item;
        if (!i_rst_n) begin
            start <= 1'b0;
            idle_left = 0;
        end else begin
            if (start && !busy)
                n_accepted++;
            if (!start || !busy) begin
                if (idle_left > 0) begin
                    idle_left--;
                    start <= 1'b0;
                end else if (pending_requests.size() != 0 &&
                             (!pending_requests[0].wait_drained || (!start && drained))) begin
                    next_item = pending_requests.pop_front();
                    i_request <= next_item.req;
                    start <= 1'b1;
                    idle_left = next_item.gap_after;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: check first, then predict for a request taken at this edge
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n) begin
            if (o_valid) begin
                n_results++;
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: stray result, expected none, actual status %0d data 'h%0h",
                             $time, o_result.status, o_result.data);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", 32'(want.status), 32'(o_result.status));
                    check_field("data", want.data, o_result.data);
                    check_field("occupancy", 32'(want.occupancy), 32'(o_result.occupancy));
                    check_field("last", 32'(want.last), 32'(o_result.last));
                end
            end
            if (start && !busy)
                apply_request(i_request);
            drained <= (awaited_results.size() == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("unique_fifo_queue: mismatch");
                    $finish;
                end
            end
        end
    end

    initial begin
        int unsigned mode;
        int unsigned r;
        bit          burst;
        logic [1:0]  op;

        // empty queue cases
        add_request(OP_POP, 32'h1234_5678, pick_gap(), 1'b0);
        add_request(OP_DUMP, '0, pick_gap(), 1'b0);
        add_request(OP_UNUSED, 32'hffff_ffff, pick_gap(), 1'b0);
        // extremes, then a duplicate, a dump and a pop
        add_request(OP_PUSH, 32'h8000_0000, pick_gap(), 1'b0);
        add_request(OP_PUSH, 32'h7fff_ffff, pick_gap(), 1'b0);
        add_request(OP_PUSH, 32'hffff_ffff, pick_gap(), 1'b0);
        add_request(OP_PUSH, 32'h0000_0000, pick_gap(), 1'b0);
        add_request(OP_PUSH, 32'h7fff_ffff, pick_gap(), 1'b0);
        add_request(OP_DUMP, 32'h5555_5555, pick_gap(), 1'b0);
        add_request(OP_POP, '0, pick_gap(), 1'b0);
        // fill up to full, then a push when full, a duplicate, a dump and an unused op
        for (int i = 0; i < QUEUE_DEPTH - 3; i++)
            add_request(OP_PUSH, 32'h1000_0000 + i, 0, 1'b0);
        add_request(OP_PUSH, 32'h2aaa_aaaa, pick_gap(), 1'b1);
        add_request(OP_PUSH, 32'hffff_ffff, pick_gap(), 1'b0);
        add_request(OP_DUMP, '0, pick_gap(), 1'b1);
        add_request(OP_UNUSED, 32'h0f0f_0f0f, pick_gap(), 1'b0);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 30 == 0) begin
                mode  = $urandom_range(0, 2);
                burst = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            case (mode)
                0:       op = (r < 75) ? OP_PUSH : (r < 85) ? OP_POP :
                              (r < 95) ? OP_DUMP : OP_UNUSED;
                1:       op = (r < 60) ? OP_POP : (r < 85) ? OP_PUSH :
                              (r < 97) ? OP_DUMP : OP_UNUSED;
                default: op = (r < 45) ? OP_PUSH : (r < 85) ? OP_POP :
                              (r < 97) ? OP_DUMP : OP_UNUSED;
            endcase
            add_request(op, pick_value(), burst ? 0 : pick_gap(), (n % 57) == 56);
        end
        n_total = pending_requests.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total || !drained)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (awaited_results.size() != 0) begin
            mismatches += awaited_results.size();
            $display("%0t: %0d results never arrived", $time, awaited_results.size());
        end
        $display("ran %0d requests giving %0d results", n_accepted, n_results);
        $display("seen %0d duplicate, %0d full and %0d empty outcomes", n_dup, n_full, n_empty);
        if (mismatches == 0)
            $display("unique_fifo_queue: match");
        else
            $display("unique_fifo_queue: mismatch");
        $finish;
    end

endmodule
